// ----- rtl/qnu_pkg.sv -----
// Shared constants for the quaternion normalize unit.
package qnu_pkg;
	localparam int COMP_WIDTH_DEF = 16;
	localparam int OUT_WIDTH      = 16;
	localparam int OUT_FRAC       = 14;
	localparam int Q_BITS         = OUT_FRAC + 1;
	localparam int LANES          = 4;
	localparam int unsigned UNIT_ONE = 1 << OUT_FRAC;
endpackage

// ----- rtl/qnu_if.sv -----
// Channel interfaces: quaternion input items and unit quaternion result items.
interface qnu_in_if
	import qnu_pkg::*;
#(parameter int W = COMP_WIDTH_DEF);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] comp_x;
	logic signed [W-1:0] comp_y;
	logic signed [W-1:0] comp_z;
	logic signed [W-1:0] comp_w;
	modport source (output valid, comp_x, comp_y, comp_z, comp_w, input ready);
	modport sink (input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

interface qnu_out_if
	import qnu_pkg::*;
;
	logic                        valid;
	logic                        ready;
	logic signed [OUT_WIDTH-1:0] unit_x;
	logic signed [OUT_WIDTH-1:0] unit_y;
	logic signed [OUT_WIDTH-1:0] unit_z;
	logic signed [OUT_WIDTH-1:0] unit_w;
	logic                        zero_magnitude;
	modport source (output valid, unit_x, unit_y, unit_z, unit_w, zero_magnitude, input ready);
	modport sink (input valid, unit_x, unit_y, unit_z, unit_w, zero_magnitude, output ready);
endinterface

// ----- rtl/quaternion_normalize_unit.sv -----
// Top level of the quaternion normalize unit.
// Usage:
//   quat   : sink channel, one quaternion item (comp_x/y/z/w, signed Q3.12 at
//            16 bits) accepted on each edge where valid and ready are high.
//   result : source channel, one item per input: unit_x/y/z/w in Q1.14,
//            rounded to nearest, ties away from zero; zero_magnitude is set and
//            the units are zero when all four components are zero.
// An item passes two front stages (squares, then sum), one stage per quotient
// bit (15 bits, MSB first) and the output register. Throughput is one item
// per cycle without back-pressure; the per-bit stages use only shifts, adds
// and one compare, so the squaring multipliers set the clock. Each stage
// holds while its successor is full and stalled, so bubbles are squeezed out
// and a result that waits does not block new items until the pipe is full.
// Reset clears every valid bit; data registers are not reset.
module quaternion_normalize_unit
	import qnu_pkg::*;
#(
	parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	qnu_in_if.sink quat,
	qnu_out_if.source result
);
	localparam int RW = 2 * COMP_WIDTH + 36;

	logic                 st_valid [Q_BITS+1];
	logic signed [RW-1:0] st_r     [Q_BITS+1][LANES];
	logic [RW-1:0]        st_v     [Q_BITS+1][LANES];
	logic [Q_BITS-1:0]    st_q     [Q_BITS+1][LANES];
	logic [RW-1:0]        st_s     [Q_BITS+1];
	logic [LANES-1:0]     st_neg   [Q_BITS+1];
	logic                 st_zero  [Q_BITS+1];
	logic                 st_en    [Q_BITS+1];
	logic [COMP_WIDTH-1:0] comp    [LANES];
	logic                 out_en;

	assign comp[0] = quat.comp_x;
	assign comp[1] = quat.comp_y;
	assign comp[2] = quat.comp_z;
	assign comp[3] = quat.comp_w;

	// front end feeds stage 0
	qnu_square #(.W(COMP_WIDTH), .RW(RW)) u_square (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (quat.valid),
		.comp     (comp),
		.in_ready (quat.ready),
		.next_en  (st_en[1]),
		.valid_s2 (st_valid[0]),
		.r_s2     (st_r[0]),
		.s_s2     (st_s[0]),
		.neg_s2   (st_neg[0]),
		.zero_s2  (st_zero[0])
	);

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			st_v[0][i] = '0;
			st_q[0][i] = '0;
		end
	end

	// stall chain: a stage loads when empty or when the next one moves
	assign out_en = !result.valid || result.ready;
	always_comb begin
		st_en[0]      = 1'b0;
		st_en[Q_BITS] = !st_valid[Q_BITS] || out_en;
		for (int k = Q_BITS - 1; k >= 1; k--) begin
			st_en[k] = !st_valid[k] || st_en[k + 1];
		end
	end

	// quotient bit stages, MSB first
	for (genvar k = 1; k <= Q_BITS; k++) begin : g_step
		qnu_root_step #(.W(COMP_WIDTH), .RW(RW), .B(Q_BITS - k)) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (st_en[k]),
			.valid_i  (st_valid[k-1]),
			.r_i      (st_r[k-1]),
			.v_i      (st_v[k-1]),
			.q_i      (st_q[k-1]),
			.s_i      (st_s[k-1]),
			.neg_i    (st_neg[k-1]),
			.zero_i   (st_zero[k-1]),
			.valid_s1 (st_valid[k]),
			.r_s1     (st_r[k]),
			.v_s1     (st_v[k]),
			.q_s1     (st_q[k]),
			.s_s1     (st_s[k]),
			.neg_s1   (st_neg[k]),
			.zero_s1  (st_zero[k])
		);
	end

	// output register: apply sign, force zeros for a zero quaternion
	function automatic logic [OUT_WIDTH-1:0] signed_unit(
		input logic [Q_BITS-1:0] q, input logic neg, input logic zero);
		logic [OUT_WIDTH-1:0] m;
		m = OUT_WIDTH'(q);
		if (zero) begin
			return '0;
		end
		return neg ? (~m + 1'b1) : m;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid <= 1'b0;
		end else if (out_en) begin
			result.valid <= st_valid[Q_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			result.unit_x <= signed_unit(st_q[Q_BITS][0], st_neg[Q_BITS][0], st_zero[Q_BITS]);
			result.unit_y <= signed_unit(st_q[Q_BITS][1], st_neg[Q_BITS][1], st_zero[Q_BITS]);
			result.unit_z <= signed_unit(st_q[Q_BITS][2], st_neg[Q_BITS][2], st_zero[Q_BITS]);
			result.unit_w <= signed_unit(st_q[Q_BITS][3], st_neg[Q_BITS][3], st_zero[Q_BITS]);
			result.zero_magnitude <= st_zero[Q_BITS];
		end
	end

	// a zero quaternion gives all-zero units
	a_zero_units: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.zero_magnitude |->
			result.unit_x == 0 && result.unit_y == 0 &&
			result.unit_z == 0 && result.unit_w == 0)
		else $error("zero magnitude with nonzero unit");

	// unit_x and unit_w stay within -1.0 .. +1.0
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |->
			result.unit_x <= 16384 && result.unit_x >= -16384 &&
			result.unit_w <= 16384 && result.unit_w >= -16384)
		else $error("unit component out of range");

	// input side only stalls when the result side is stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!quat.ready |-> result.valid && !result.ready)
		else $error("input stalled without output back-pressure");
endmodule

// ----- rtl/qnu_square.sv -----
// Front stages: magnitudes and squares, then sum of squares and initial remainders.
module qnu_square
	import qnu_pkg::*;
#(
	parameter int W  = COMP_WIDTH_DEF,
	parameter int RW = 2 * W + 36
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [W-1:0]         comp [LANES],
	output logic                 in_ready,
	input  logic                 next_en,
	output logic                 valid_s2,
	output logic signed [RW-1:0] r_s2 [LANES],
	output logic [RW-1:0]        s_s2,
	output logic [LANES-1:0]     neg_s2,
	output logic                 zero_s2
);
	logic             valid_s1;
	logic [2*W-1:0]   sq_s1 [LANES];
	logic [LANES-1:0] neg_s1;
	logic             en1, en2;
	logic [RW-1:0]    sum;
	logic [W-1:0]     mag [LANES];

	assign en2      = !valid_s2 || next_en;
	assign en1      = !valid_s1 || en2;
	assign in_ready = en1;

	// absolute value of each component, kept at component width
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			mag[i] = comp[i][W-1] ? W'(~comp[i] + 1'b1) : comp[i];
		end
	end

	// stage 1: absolute values and squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int i = 0; i < LANES; i++) begin
				neg_s1[i] <= comp[i][W-1];
				sq_s1[i]  <= mag[i] * mag[i];
			end
		end
	end

	// stage 2: sum of squares and remainder a^2 * 2^30 - S per lane
	always_comb begin
		sum = '0;
		for (int i = 0; i < LANES; i++) begin
			sum = sum + RW'(sq_s1[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			s_s2    <= sum;
			zero_s2 <= (sum == '0);
			neg_s2  <= neg_s1;
			for (int i = 0; i < LANES; i++) begin
				r_s2[i] <= $signed((RW'(sq_s1[i]) << (2 * OUT_FRAC + 2)) - sum);
			end
		end
	end
endmodule

// ----- rtl/qnu_root_step.sv -----
// One bit of the quotient search for all four lanes, shift-and-add only.
module qnu_root_step
	import qnu_pkg::*;
#(
	parameter int W  = COMP_WIDTH_DEF,
	parameter int RW = 2 * W + 36,
	parameter int B  = OUT_FRAC
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_i,
	input  logic signed [RW-1:0] r_i [LANES],
	input  logic [RW-1:0]        v_i [LANES],
	input  logic [Q_BITS-1:0]    q_i [LANES],
	input  logic [RW-1:0]        s_i,
	input  logic [LANES-1:0]     neg_i,
	input  logic                 zero_i,
	output logic                 valid_s1,
	output logic signed [RW-1:0] r_s1 [LANES],
	output logic [RW-1:0]        v_s1 [LANES],
	output logic [Q_BITS-1:0]    q_s1 [LANES],
	output logic [RW-1:0]        s_s1,
	output logic [LANES-1:0]     neg_s1,
	output logic                 zero_s1
);
	logic [RW-1:0] delta [LANES];
	logic [RW-1:0] diff  [LANES];
	logic          take  [LANES];

	// trial t = q | 2^B: (2t-1)^2 S - (2q-1)^2 S = ((2 S q) + S 2^B - S) 2^(B+2)
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			delta[i] = ((v_i[i] << 1) + (s_i << B) - s_i) << (B + 2);
			diff[i]  = RW'(r_i[i]) - delta[i];
			take[i]  = !q_i[i][OUT_FRAC] && !diff[i][RW-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1    <= s_i;
			neg_s1  <= neg_i;
			zero_s1 <= zero_i;
			for (int i = 0; i < LANES; i++) begin
				r_s1[i] <= take[i] ? $signed(diff[i]) : r_i[i];
				v_s1[i] <= take[i] ? (v_i[i] + (s_i << B)) : v_i[i];
				q_s1[i] <= take[i] ? (q_i[i] | Q_BITS'(1 << B)) : q_i[i];
			end
		end
	end
endmodule
